// File: rtl/huffman_code_builder_core_assert.svh
// ----------------------------------------------------------------------------
// Huffman code builder assertion macros
// Shared property forms for the port checker. clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BUILDER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_CORE_ASSERT_SVH

// same-cycle implication
`define HCB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Widths and constants shared by the Huffman code builder and its checker.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int LEAVES_DEF = 32;    // default leaf capacity
  localparam int SYM_W      = 8;     // leaf symbol
  localparam int WGT_W      = 16;    // leaf weight
  localparam int SUM_W      = 21;    // node weight (sum of leaf weights)
  localparam int LEN_W      = 5;     // code length
  localparam int CODE_W     = 31;    // code bits

  // search start value, above any reachable node weight
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

endpackage

// File: rtl/huffman_code_builder_core.sv
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// Loads leaf words, builds a Huffman tree in node memories, emits one code
// word per leaf.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one leaf word per accepted cycle (symbol, weight).
//   Leaves beyond LEAVES are dropped. A word with in_last_leaf set closes the
//   set and starts the build; in_stall stays high until the last code loads.
//   Output channel (out_*): one code word per loaded leaf, in load order,
//   out_last_code set on the final one. The code is right-aligned, root-side
//   bit in the MSB; a single leaf gets length 0.
// Build and emit:
//   Each of the n-1 merges scans the node weight memory once, one node per
//   cycle; the merge that creates node top (n <= top <= 2n-2) reads nodes
//   0 to top-1. Each code then takes one parent memory read per tree level.
// Reset: synchronous, active low; clears the leaf count, the parent-set
//   flags and the output valid. Node memories need no clearing.
// Stall: out_valid/out_* hold while out_stall is high; the builder waits in
//   its emit step until the output register frees up.
// ----------------------------------------------------------------------------
module huffman_code_builder_core #(
  parameter int LEAVES = hcb_pkg::LEAVES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // leaf input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [hcb_pkg::SYM_W-1:0]  in_symbol,
  input  logic [hcb_pkg::WGT_W-1:0]  in_weight,
  input  logic                       in_last_leaf,
  // code output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hcb_pkg::SYM_W-1:0]  out_code_symbol,
  output logic [hcb_pkg::LEN_W-1:0]  out_code_length,
  output logic [hcb_pkg::CODE_W-1:0] out_code_bits,
  output logic                       out_last_code
);
  import hcb_pkg::*;

  localparam int NODES  = 2 * LEAVES - 1;
  localparam int NODE_W = $clog2(NODES);
  localparam int LEAF_W = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int CNT_W  = $clog2(LEAVES + 1);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MRG0  = 3'd2;  // sum node, left child link
  localparam logic [2:0] S_MRG1  = 3'd3;  // right child link
  localparam logic [2:0] S_WSTRT = 3'd4;
  localparam logic [2:0] S_WSTEP = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;        // leaves held
  logic [CNT_W-1:0]  n_r, n_nxt;            // leaves in this build
  logic [NODE_W-1:0] top_r, top_nxt;        // node being created
  logic [NODE_W-1:0] k_r, k_nxt;            // scan read index
  logic              s_vld_r, s_vld_nxt;    // weight read in flight
  logic [NODE_W-1:0] s_idx_r, s_idx_nxt;
  logic [SUM_W-1:0]  best_r, best_nxt;
  logic [SUM_W-1:0]  next_r, next_nxt;
  logic [NODE_W-1:0] bi_r, bi_nxt;
  logic [NODE_W-1:0] ni_r, ni_nxt;
  logic [NODES-1:0]  pset_r, pset_nxt;      // node has a parent
  logic [LEAF_W-1:0] i_r, i_nxt;            // leaf being coded
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CODE_W-1:0] bits_r, bits_nxt;
  logic              out_valid_r;

  // output payload
  logic [SYM_W-1:0]  out_sym_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [CODE_W-1:0] out_bits_r;
  logic              out_last_r;

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]  wmem [NODES];          // node weight
  logic [NODE_W:0]   pmem [NODES];          // {is_right, parent}
  logic [SYM_W-1:0]  smem [LEAVES];         // leaf symbol

  logic              w_we, w_re;
  logic [NODE_W-1:0] w_wa;
  logic [SUM_W-1:0]  w_wd, w_q_r;
  logic              p_we, p_re;
  logic [NODE_W-1:0] p_wa, p_ra;
  logic [NODE_W:0]   p_wd, p_q_r;
  logic              s_we, s_re;
  logic [SYM_W-1:0]  s_q_r;

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_wa] <= w_wd;
    end
    if (w_re) begin
      w_q_r <= wmem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_wa] <= p_wd;
    end
    if (p_re) begin
      p_q_r <= pmem[p_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[cnt_r[LEAF_W-1:0]] <= in_symbol;
    end
    if (s_re) begin
      s_q_r <= smem[i_r];
    end
  end

  // --------------------------------------------------------------------------
  // next-state logic
  // --------------------------------------------------------------------------
  logic              in_acc;
  logic              room;
  logic [CNT_W-1:0]  n_load;
  logic [CNT_W:0]    two_n;
  logic [NODE_W-1:0] top_last;
  logic [LEAF_W-1:0] i_last;
  logic              out_free;
  logic              load_out;
  logic [NODE_W-1:0] par;
  logic              par_right;

  assign in_acc    = in_valid && !in_stall;
  assign room      = (cnt_r < CNT_W'(LEAVES));
  assign n_load    = room ? (cnt_r + CNT_W'(1)) : cnt_r;
  assign two_n     = {n_r, 1'b0};
  assign top_last  = NODE_W'(two_n - (CNT_W + 1)'(2));
  assign i_last    = LEAF_W'(n_r - CNT_W'(1));
  assign out_free  = !out_valid_r || !out_stall;
  assign par       = p_q_r[NODE_W-1:0];
  assign par_right = p_q_r[NODE_W];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    top_nxt   = top_r;
    k_nxt     = k_r;
    s_vld_nxt = 1'b0;
    s_idx_nxt = k_r;
    best_nxt  = best_r;
    next_nxt  = next_r;
    bi_nxt    = bi_r;
    ni_nxt    = ni_r;
    pset_nxt  = pset_r;
    i_nxt     = i_r;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    bits_nxt  = bits_r;
    load_out  = 1'b0;

    w_we = 1'b0;
    w_re = 1'b0;
    w_wa = top_r;
    w_wd = best_r + next_r;
    p_we = 1'b0;
    p_re = 1'b0;
    p_wa = bi_r;
    p_wd = {1'b0, top_r};
    p_ra = NODE_W'(i_r);
    s_we = 1'b0;
    s_re = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (room) begin
            w_we    = 1'b1;
            w_wa    = NODE_W'(cnt_r);
            w_wd    = {{(SUM_W - WGT_W){1'b0}}, in_weight};
            s_we    = 1'b1;
            cnt_nxt = n_load;
          end
          if (in_last_leaf) begin
            n_nxt    = n_load;
            top_nxt  = NODE_W'(n_load);
            pset_nxt = '0;
            k_nxt    = '0;
            best_nxt = SUM_MAX;
            next_nxt = SUM_MAX;
            bi_nxt   = '0;
            ni_nxt   = '0;
            i_nxt    = '0;
            // one leaf: nothing to merge
            state_nxt = (n_load == CNT_W'(1)) ? S_WSTRT : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // fold in the weight read last cycle
        if (s_vld_r && !pset_r[s_idx_r]) begin
          if (w_q_r < best_r) begin
            next_nxt = best_r;
            ni_nxt   = bi_r;
            best_nxt = w_q_r;
            bi_nxt   = s_idx_r;
          end else if (w_q_r < next_r) begin
            next_nxt = w_q_r;
            ni_nxt   = s_idx_r;
          end
        end
        if (k_r < top_r) begin
          w_re      = 1'b1;
          s_vld_nxt = 1'b1;
          s_idx_nxt = k_r;
          k_nxt     = k_r + NODE_W'(1);
        end else begin
          state_nxt = S_MRG0;
        end
      end

      S_MRG0: begin
        w_we         = 1'b1;
        p_we         = 1'b1;
        p_wa         = bi_r;
        p_wd         = {1'b0, top_r};
        pset_nxt[bi_r] = 1'b1;
        state_nxt    = S_MRG1;
      end

      S_MRG1: begin
        p_we         = 1'b1;
        p_wa         = ni_r;
        p_wd         = {1'b1, top_r};
        pset_nxt[ni_r] = 1'b1;
        top_nxt      = top_r + NODE_W'(1);
        k_nxt        = '0;
        best_nxt     = SUM_MAX;
        next_nxt     = SUM_MAX;
        bi_nxt       = '0;
        ni_nxt       = '0;
        state_nxt    = (top_r == top_last) ? S_WSTRT : S_SCAN;
      end

      S_WSTRT: begin
        p_re      = 1'b1;
        p_ra      = NODE_W'(i_r);
        s_re      = 1'b1;
        cur_nxt   = NODE_W'(i_r);
        len_nxt   = '0;
        bits_nxt  = '0;
        state_nxt = S_WSTEP;
      end

      S_WSTEP: begin
        // parent entry of cur_r is on p_q_r
        if (pset_r[cur_r] && (len_r < LEN_W'(CODE_W))) begin
          bits_nxt = bits_r | (CODE_W'(par_right) << len_r);
          len_nxt  = len_r + LEN_W'(1);
          cur_nxt  = par;
          p_re     = 1'b1;
          p_ra     = par;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (i_r == i_last) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_r + LEAF_W'(1);
            state_nxt = S_WSTRT;
          end
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      pset_r  <= '0;
      s_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pset_r  <= pset_nxt;
      s_vld_r <= s_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    top_r   <= top_nxt;
    k_r     <= k_nxt;
    s_idx_r <= s_idx_nxt;
    best_r  <= best_nxt;
    next_r  <= next_nxt;
    bi_r    <= bi_nxt;
    ni_r    <= ni_nxt;
    i_r     <= i_nxt;
    cur_r   <= cur_nxt;
    len_r   <= len_nxt;
    bits_r  <= bits_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sym_r  <= s_q_r;
      out_len_r  <= len_r;
      out_bits_r <= bits_r;
      out_last_r <= (i_r == i_last);
    end
  end

  assign in_stall        = (state_r != S_LOAD);
  assign out_valid       = out_valid_r;
  assign out_code_symbol = out_sym_r;
  assign out_code_length = out_len_r;
  assign out_code_bits   = out_bits_r;
  assign out_last_code   = out_last_r;

endmodule

// File: rtl/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker
// Port-level checks for huffman_code_builder_core, attached by bind.
// ----------------------------------------------------------------------------
`include "huffman_code_builder_core_assert.svh"

module hcb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_last_leaf,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [hcb_pkg::SYM_W-1:0]  out_code_symbol,
  input logic [hcb_pkg::LEN_W-1:0]  out_code_length,
  input logic [hcb_pkg::CODE_W-1:0] out_code_bits,
  input logic                       out_last_code
);
  import hcb_pkg::*;

  // stalled code word holds
  `HCB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_code_symbol) && $stable(out_code_length) && $stable(out_code_bits) && $stable(out_last_code), "stalled code word changed")

  // no code bits above the code length
  `HCB_ASSERT_SAME(a_bits_fit, out_valid, (out_code_bits >> out_code_length) == '0, "code bits beyond length")

  // final leaf starts the build, input closes
  `HCB_ASSERT_NEXT(a_build_starts, in_valid && !in_stall && in_last_leaf, in_stall, "input open after final leaf")

  // plain leaves keep the loader open
  `HCB_ASSERT_NEXT(a_load_open, in_valid && !in_stall && !in_last_leaf, !in_stall, "input closed after plain leaf")

endmodule

bind huffman_code_builder_core hcb_checker u_hcb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_last_leaf    (in_last_leaf),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_code_symbol (out_code_symbol),
  .out_code_length (out_code_length),
  .out_code_bits   (out_code_bits),
  .out_last_code   (out_last_code)
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Feeds leaf words into huffman_code_builder_core and checks every code word
// it returns against a predictor that builds the same tree in testbench state.
// Directed sets cover the corner cases. Full and overflowing sets come next,
// then random sets. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import hcb_pkg::*;

  localparam int          LEAVES     = LEAVES_DEF;
  localparam int          NODES      = 2 * LEAVES - 1;
  localparam logic [5:0]  NO_PARENT  = 6'd63;
  localparam int          CYCLE_CAP  = 1_000_000;
  localparam int          RAND_WORDS = 200;

  // weight flavors for random sets
  typedef enum int {
    WGT_FULL, WGT_TINY, WGT_EDGES, WGT_BYTE
  } wgt_mode_t;

  // one expected code word
  typedef struct {
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
    logic              last;
  } code_word_t;

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [SYM_W-1:0]  in_symbol    = '0;
  logic [WGT_W-1:0]  in_weight    = '0;
  logic              in_last_leaf = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [SYM_W-1:0]  out_code_symbol;
  logic [LEN_W-1:0]  out_code_length;
  logic [CODE_W-1:0] out_code_bits;
  logic              out_last_code;

  // predictor copy of the block state
  logic [SUM_W-1:0]  node_wt  [NODES];
  logic [5:0]        node_up  [NODES];
  logic [5:0]        node_lo  [NODES];
  logic [SYM_W-1:0]  leaf_sym [LEAVES];
  int unsigned       held_leaves;

  code_word_t        codes_due[$];

  // run bookkeeping
  bit                steady;         // no idling on either side while set
  int unsigned       mismatches;
  int unsigned       useful_words;   // stored or build-starting leaf words
  int unsigned       builds;
  int unsigned       widest_build;
  int unsigned       codes_checked;
  int unsigned       cycles;

  huffman_code_builder_core #(
    .LEAVES(LEAVES)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .in_weight      (in_weight),
    .in_last_leaf   (in_last_leaf),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_symbol(out_code_symbol),
    .out_code_length(out_code_length),
    .out_code_bits  (out_code_bits),
    .out_last_code  (out_last_code)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop; the slowest legal run stays far below this
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout: run passed %0d cycles", CYCLE_CAP);
      $display("Mismatches found");
      $finish;
    end
  end

  // a break with a chance of about 31 in 100, none while steady is set
  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 31);
  endfunction

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Build the tree over n held leaves and queue one code word per leaf.
  task automatic build_tree_codes(input int unsigned n);
    logic [SUM_W-1:0]  best, second;
    logic [5:0]        bi, si;
    logic [CODE_W-1:0] bits;
    int unsigned       top, len, cur;
    code_word_t        cw;
    for (int k = 0; k < NODES; k++) node_up[k] = NO_PARENT;
    // n-1 merges; the scan keeps the two lightest orphans, lower index on ties
    for (int unsigned step = 0; step + 1 < n; step++) begin
      best   = SUM_MAX;
      second = SUM_MAX;
      bi     = '0;
      si     = '0;
      top    = n + step;
      for (int unsigned k = 0; k < top; k++) begin
        if (node_up[k] == NO_PARENT) begin
          if (node_wt[k] < best) begin
            second = best;
            si     = bi;
            best   = node_wt[k];
            bi     = 6'(k);
          end else if (node_wt[k] < second) begin
            second = node_wt[k];
            si     = 6'(k);
          end
        end
      end
      node_up[bi]  = 6'(top);
      node_up[si]  = 6'(top);
      node_wt[top] = best + second;
      node_lo[top] = bi;
    end
    // walk each leaf up to the root; the leaf-side bit lands in bit 0
    for (int unsigned i = 0; i < n; i++) begin
      bits = '0;
      len  = 0;
      cur  = i;
      while (node_up[cur] != NO_PARENT && len < CODE_W) begin
        if (node_lo[node_up[cur]] != 6'(cur)) bits[len] = 1'b1;
        cur = node_up[cur];
        len++;
      end
      cw.sym  = leaf_sym[i];
      cw.len  = LEN_W'(len);
      cw.bits = bits;
      cw.last = (i + 1 == n);
      codes_due.push_back(cw);
    end
    builds++;
    if (n > widest_build) widest_build = n;
  endtask

  // Accepted leaf word: store it if there is room, build on the last one.
  task automatic absorb_leaf(input logic [SYM_W-1:0] sym, input logic [WGT_W-1:0] wgt,
                             input logic last);
    if (held_leaves < LEAVES) begin
      leaf_sym[held_leaves] = sym;
      node_wt[held_leaves]  = SUM_W'(wgt);
      held_leaves++;
      useful_words++;
    end else if (last) begin
      useful_words++;
    end
    if (last) begin
      build_tree_codes(held_leaves);
      held_leaves = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver side
  // --------------------------------------------------------------------------

  // Send one leaf word; returns right after the edge that accepted it.
  task automatic send_leaf(input logic [SYM_W-1:0] sym, input logic [WGT_W-1:0] wgt,
                           input logic last);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_symbol    <= sym;
    in_weight    <= wgt;
    in_last_leaf <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_leaf(sym, wgt, last);
  endtask

  // Hold the input off until every pending code word has been taken.
  task automatic wait_for_codes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (codes_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WGT_W-1:0] pick_weight(input wgt_mode_t mode);
    case (mode)
      WGT_TINY:  return WGT_W'($urandom_range(3));
      WGT_EDGES: return $urandom_range(1) ? '1 : '0;
      WGT_BYTE:  return WGT_W'($urandom_range(255));
      default:   return WGT_W'($urandom_range(65535));
    endcase
  endfunction

  // One set of leaves; with spill, words past capacity follow and the last
  // of them closes the set.
  task automatic send_set(input int unsigned size, input bit spill, input wgt_mode_t mode);
    for (int unsigned i = 0; i < size; i++)
      send_leaf(SYM_W'($urandom), pick_weight(mode), (i + 1 == size) && !spill);
    if (spill) begin
      repeat ($urandom_range(3)) send_leaf(SYM_W'($urandom), pick_weight(mode), 1'b0);
      send_leaf(SYM_W'($urandom), pick_weight(mode), 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, check each accepted code word in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : code_checker
    code_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      codes_checked++;
      if (codes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected code word: symbol %0d length %0d bits %h last %0b",
                   out_code_symbol, out_code_length, out_code_bits, out_last_code);
      end else begin
        want = codes_due.pop_front();
        if (out_code_symbol !== want.sym || out_code_length !== want.len ||
            out_code_bits !== want.bits || out_last_code !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Code word mismatch: expected sym %0d len %0d bits %h last %0b,",
                      " got sym %0d len %0d bits %h last %0b"},
                     want.sym, want.len, want.bits, want.last, out_code_symbol,
                     out_code_length, out_code_bits, out_last_code);
        end
      end
    end
    out_stall <= take_break();
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // lone leaf: empty code, both weight extremes
  task automatic test_single_leaf();
    send_leaf(8'hFF, 16'hFFFF, 1'b1);
    send_leaf(8'h00, 16'h0000, 1'b1);
  endtask

  // two leaves: extreme weights, then a tie won by the lower index
  task automatic test_pairs();
    send_leaf(8'h00, 16'hFFFF, 1'b0);
    send_leaf(8'hFF, 16'h0000, 1'b1);
    send_leaf(8'hA5, 16'h1234, 1'b0);
    send_leaf(8'h5A, 16'h1234, 1'b1);
  endtask

  // all-equal weights: merged nodes lose ties to the leaves before them
  task automatic test_ties();
    for (int i = 0; i < 5; i++) send_leaf(SYM_W'(8'h10 + i), 16'd7, i == 4);
    for (int i = 0; i < 4; i++) send_leaf(SYM_W'(8'hF0 + i), 16'd0, i == 3);
  endtask

  // descending powers of two give a one-sided tree
  task automatic test_skewed();
    for (int i = 0; i < 6; i++) send_leaf(SYM_W'(8'h80 + i), WGT_W'(32 >> i), i == 5);
  endtask

  // full sets, spill past capacity, and a deep Fibonacci-weighted tree
  task automatic test_capacity();
    int unsigned a, b, t;
    send_set(LEAVES, 1'b0, WGT_FULL);
    wait_for_codes();
    send_set(LEAVES, 1'b1, WGT_TINY);
    a = 1;
    b = 1;
    for (int i = 0; i < LEAVES; i++) begin
      send_leaf(SYM_W'(i), (a > 65535) ? 16'hFFFF : WGT_W'(a), i == LEAVES - 1);
      t = a + b;
      a = b;
      b = t;
    end
  endtask

  // random sets, mostly small; a steady stretch in the middle
  task automatic test_random_sets();
    int unsigned start, size, pick, sets;
    bit          spill;
    start = useful_words;
    sets  = 0;
    while (useful_words < start + RAND_WORDS) begin
      steady = (useful_words >= start + 60) && (useful_words < start + 140);
      pick   = $urandom_range(99);
      if (pick < 5)       size = 1;
      else if (pick < 80) size = $urandom_range(8, 2);
      else if (pick < 95) size = $urandom_range(20, 9);
      else                size = $urandom_range(LEAVES, 21);
      spill = (size == LEAVES) && $urandom_range(1);
      send_set(size, spill, wgt_mode_t'($urandom_range(3)));
      sets++;
      // now and then let the whole result train drain first
      if (sets % 6 == 0) wait_for_codes();
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_single_leaf();
    test_pairs();
    test_ties();
    test_skewed();
    wait_for_codes();
    test_capacity();
    wait_for_codes();
    test_random_sets();
    wait_for_codes();
    // quiet tail: nothing more may appear
    repeat (200) @(posedge clk);
    if (codes_due.size() != 0) begin
      $display("%0d expected code words never arrived", codes_due.size());
      mismatches += codes_due.size();
    end
    $display("Covered %0d leaf words in %0d tree builds (up to %0d leaves),",
             useful_words, builds, widest_build);
    $display("with %0d code words checked under random idling and stalls.", codes_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
